### rtl/core/rs_systematic_encoder_gf256_macros.svh
// Assertion macros for the RS(GF256) systematic encoder.
// No dependencies; included by the top level only.
`ifndef RS_SYSTEMATIC_ENCODER_GF256_MACROS_SVH
`define RS_SYSTEMATIC_ENCODER_GF256_MACROS_SVH

// same-cycle implication
`define RSENC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rsenc: same-cycle check failed");

// next-cycle implication
`define RSENC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rsenc: next-cycle check failed");

`endif

### rtl/core/rsenc_pkg.sv
// Shared types, state encoding and GF(2^8) arithmetic for the RS encoder.
// No dependencies.
package rsenc_pkg;

    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam int MAX_PARITY = 32;

    typedef logic [MAX_PARITY:0][7:0] gen_taps_t;

    typedef enum logic {
        ST_DATA,
        ST_PARITY
    } enc_state_t;

    typedef struct packed {
        logic update;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        cell_ctl_t chain;
        logic      load_data;
        logic      load_parity;
        logic      last;
    } ctrl_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // g[j] = coefficient of x^j in prod (x + alpha^i), i = 0..p-1
    function automatic gen_taps_t gen_poly(input int p);
        gen_taps_t  g;
        gen_taps_t  nxt;
        logic [7:0] root;
        g    = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < p; i++) begin
            nxt = '0;
            for (int j = 0; j <= i; j++) begin
                nxt[j]     = nxt[j] ^ gf_mul(g[j], root);
                nxt[j + 1] = nxt[j + 1] ^ g[j];
            end
            g    = nxt;
            root = gf_mul(root, 8'h02);
        end
        return g;
    endfunction

endpackage

### rtl/core/rs_systematic_encoder_gf256.sv
// A data byte is registered onto m_ in the cycle after acceptance; parity follows the last data byte.
// Throughput: one data byte per cycle unless m_ready stalls the output; each block then emits PARITY_BYTES
// parity bytes with s_ready low, so a block is DATA_BYTES + PARITY_BYTES bytes long (30 by default).
// Rate is set by the single output register shared by data echo and parity emission.
// Reset (aresetn, synchronous, active low) clears all parity cells, counters and m_valid.
// Depends on rsenc_pkg, rsenc_ctrl, rsenc_cell and the assertion macro header.
`include "rs_systematic_encoder_gf256_macros.svh"
module rs_systematic_encoder_gf256
    import rsenc_pkg::*;
#(
    parameter int DATA_BYTES   = 14,
    parameter int PARITY_BYTES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_code_byte,
    output logic       m_is_parity,
    output logic       m_block_end
);

    localparam gen_taps_t GEN_TAPS = gen_poly(PARITY_BYTES);

    ctrl_t      ctrl;
    logic       out_free;
    logic [7:0] cell_val [PARITY_BYTES];
    logic [7:0] fb;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_code_byte_reg, m_code_byte_next;
    logic       m_is_parity_reg, m_is_parity_next;
    logic       m_block_end_reg, m_block_end_next;

    assign out_free = !m_valid_reg || m_ready;
    assign fb       = s_data_byte ^ cell_val[0];

    rsenc_ctrl #(
        .DATA_BYTES  (DATA_BYTES),
        .PARITY_BYTES(PARITY_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .out_free(out_free),
        .s_ready (s_ready),
        .ctrl    (ctrl)
    );

    for (genvar k = 0; k < PARITY_BYTES; k++) begin : g_cell
        logic [7:0] from_next;
        if (k == PARITY_BYTES - 1) begin : g_tail
            assign from_next = '0;
        end else begin : g_body
            assign from_next = cell_val[k + 1];
        end
        rsenc_cell #(
            .TAP(GEN_TAPS[k + 1])
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctrl.chain),
            .fb       (fb),
            .from_next(from_next),
            .value    (cell_val[k])
        );
    end

    always_comb begin
        m_valid_next     = m_valid_reg && !m_ready;
        m_code_byte_next = m_code_byte_reg;
        m_is_parity_next = m_is_parity_reg;
        m_block_end_next = m_block_end_reg;
        if (ctrl.load_data) begin
            m_valid_next     = 1'b1;
            m_code_byte_next = s_data_byte;
            m_is_parity_next = 1'b0;
            m_block_end_next = 1'b0;
        end else if (ctrl.load_parity) begin
            m_valid_next     = 1'b1;
            m_code_byte_next = cell_val[0];
            m_is_parity_next = 1'b1;
            m_block_end_next = ctrl.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_code_byte_reg <= m_code_byte_next;
        m_is_parity_reg <= m_is_parity_next;
        m_block_end_reg <= m_block_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_code_byte = m_code_byte_reg;
    assign m_is_parity = m_is_parity_reg;
    assign m_block_end = m_block_end_reg;

    // no input while a non-final parity byte is pending
    `RSENC_ASSERT_NOW(a_no_input_mid_parity, aclk, aresetn, m_valid && m_is_parity && !m_block_end, !s_ready)
    // input only taken when the output register can take its echo
    `RSENC_ASSERT_NOW(a_accept_needs_room, aclk, aresetn, s_valid && s_ready, !m_valid || m_ready)
    // chain drained to zero after the last parity transaction is loaded
    `RSENC_ASSERT_NEXT(a_chain_clear, aclk, aresetn, ctrl.load_parity && ctrl.last, cell_val[0] == 8'h00)

endmodule

### rtl/core/rsenc_cell.sv
// One parity LFSR cell: holds one parity byte, constant GF multiplier on feedback.
// Depends on rsenc_pkg.
module rsenc_cell
    import rsenc_pkg::*;
#(
    parameter logic [7:0] TAP = 8'h01
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  logic [7:0] fb,
    input  logic [7:0] from_next,
    output logic [7:0] value
);

    logic [7:0] value_reg;
    logic [7:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.update) begin
            value_next = from_next ^ gf_mul(TAP, fb);
        end else if (ctl.shift) begin
            value_next = from_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

### rtl/core/rsenc_ctrl.sv
// Block sequencer: data/parity phases, byte and parity counters, cell control.
// Depends on rsenc_pkg.
module rsenc_ctrl
    import rsenc_pkg::*;
#(
    parameter int DATA_BYTES   = 14,
    parameter int PARITY_BYTES = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  out_free,
    output logic  s_ready,
    output ctrl_t ctrl
);

    localparam int BCW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int PCW = $clog2(PARITY_BYTES);

    enc_state_t     state_reg, state_next;
    logic [BCW-1:0] byte_cnt_reg, byte_cnt_next;
    logic [PCW-1:0] par_cnt_reg, par_cnt_next;
    logic           accept;
    logic           last_data;
    logic           last_parity;

    assign accept      = s_valid && s_ready;
    assign last_data   = (byte_cnt_reg == BCW'(DATA_BYTES - 1));
    assign last_parity = (par_cnt_reg == PCW'(PARITY_BYTES - 1));

    always_comb begin
        state_next    = state_reg;
        byte_cnt_next = byte_cnt_reg;
        par_cnt_next  = par_cnt_reg;
        case (state_reg)
            ST_DATA: begin
                if (accept) begin
                    if (last_data) begin
                        byte_cnt_next = '0;
                        par_cnt_next  = '0;
                        state_next    = ST_PARITY;
                    end else begin
                        byte_cnt_next = byte_cnt_reg + 1'b1;
                    end
                end
            end
            ST_PARITY: begin
                if (out_free) begin
                    par_cnt_next = par_cnt_reg + 1'b1;
                    if (last_parity) begin
                        state_next = ST_DATA;
                    end
                end
            end
            default: begin
                state_next = ST_DATA;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        ctrl    = '0;
        case (state_reg)
            ST_DATA: begin
                s_ready              = out_free;
                ctrl.chain.update    = s_valid && out_free;
                ctrl.load_data       = s_valid && out_free;
            end
            ST_PARITY: begin
                ctrl.chain.shift = out_free;
                ctrl.load_parity = out_free;
                ctrl.last        = last_parity;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_DATA;
            byte_cnt_reg <= '0;
            par_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            par_cnt_reg  <= par_cnt_next;
        end
    end

endmodule
